/* rtl/ir_remote_frame_encoder_defines.svh */
// Assertion macros shared by the IR frame encoder RTL.
// Needs a clk and an active-low rst_n in the scope of use.
`ifndef IR_REMOTE_FRAME_ENCODER_DEFINES_SVH
`define IR_REMOTE_FRAME_ENCODER_DEFINES_SVH

// Check outside reset.
`define IRFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also covers the reset cycles.
`define IRFE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/irfe_pkg.sv */
// Types, timing constants and frame program tables for the IR frame encoder.
// No dependencies.
`default_nettype none
package irfe_pkg;

  localparam int ProtoW = 5;
  localparam int WordW  = 32;
  localparam int PulseW = 14;
  localparam int SpaceW = 16;
  localparam int DurW   = 16;
  localparam int SegW   = 4;
  localparam int BitW   = 5;
  localparam int CntW   = 6;

  localparam logic [2:0] K_END   = 3'd0;
  localparam logic [2:0] K_MARK  = 3'd1;
  localparam logic [2:0] K_GAP   = 3'd2;
  localparam logic [2:0] K_DIST  = 3'd3;
  localparam logic [2:0] K_MANCH = 3'd4;

  localparam logic [4:0] V_ZERO   = 5'd0;
  localparam logic [4:0] V_ONE    = 5'd1;
  localparam logic [4:0] V_TWO    = 5'd2;
  localparam logic [4:0] V_EIGHT  = 5'd3;
  localparam logic [4:0] V_FOURT  = 5'd4;
  localparam logic [4:0] V_RC5F   = 5'd5;
  localparam logic [4:0] V_RC5XF  = 5'd6;
  localparam logic [4:0] V_RC5SZF = 5'd7;
  localparam logic [4:0] V_S      = 5'd8;
  localparam logic [4:0] V_S6     = 5'd9;
  localparam logic [4:0] V_S8     = 5'd10;
  localparam logic [4:0] V_S16    = 5'd11;
  localparam logic [4:0] V_S24    = 5'd12;
  localparam logic [4:0] V_NS     = 5'd13;
  localparam logic [4:0] V_NS8    = 5'd14;
  localparam logic [4:0] V_SONY12 = 5'd15;
  localparam logic [4:0] V_SONY15 = 5'd16;
  localparam logic [4:0] V_SONY20 = 5'd17;
  localparam logic [4:0] V_JVC    = 5'd18;

  localparam logic [ProtoW-1:0] P_RC5     = 5'd0;
  localparam logic [ProtoW-1:0] P_RC5X    = 5'd1;
  localparam logic [ProtoW-1:0] P_RC5SZ   = 5'd2;
  localparam logic [ProtoW-1:0] P_SONY12  = 5'd3;
  localparam logic [ProtoW-1:0] P_SONY15  = 5'd4;
  localparam logic [ProtoW-1:0] P_SONY20  = 5'd5;
  localparam logic [ProtoW-1:0] P_JVC     = 5'd6;
  localparam logic [ProtoW-1:0] P_NEC     = 5'd7;
  localparam logic [ProtoW-1:0] P_NECX    = 5'd8;
  localparam logic [ProtoW-1:0] P_NEC32   = 5'd9;
  localparam logic [ProtoW-1:0] P_SANYO   = 5'd10;
  localparam logic [ProtoW-1:0] P_RC6_0   = 5'd11;
  localparam logic [ProtoW-1:0] P_RC6_20  = 5'd12;
  localparam logic [ProtoW-1:0] P_RC6_24  = 5'd13;
  localparam logic [ProtoW-1:0] P_RC6_32  = 5'd14;
  localparam logic [ProtoW-1:0] P_RC6_MCE = 5'd15;
  localparam logic [ProtoW-1:0] P_SHARP   = 5'd16;

  localparam logic [DurW-1:0] T_RC5     = 16'd889;
  localparam logic [DurW-1:0] T_RC5_GAP = 16'd3556;
  localparam logic [DurW-1:0] T_RC6     = 16'd444;
  localparam logic [DurW-1:0] T_RC6_2   = 16'd889;
  localparam logic [DurW-1:0] T_RC6_LD  = 16'd2667;
  localparam logic [DurW-1:0] T_SONY    = 16'd600;
  localparam logic [DurW-1:0] T_SONY_2  = 16'd1200;
  localparam logic [DurW-1:0] T_SONY_LD = 16'd2400;
  localparam logic [DurW-1:0] T_JVC     = 16'd525;
  localparam logic [DurW-1:0] T_JVC_3   = 16'd1575;
  localparam logic [DurW-1:0] T_JVC_LM  = 16'd8400;
  localparam logic [DurW-1:0] T_JVC_LS  = 16'd4200;
  localparam logic [DurW-1:0] T_NEC     = 16'd563;
  localparam logic [DurW-1:0] T_NEC_1   = 16'd1688;
  localparam logic [DurW-1:0] T_NEC_LM  = 16'd9000;
  localparam logic [DurW-1:0] T_NEC_LS  = 16'd4500;
  localparam logic [DurW-1:0] T_SH_MARK = 16'd320;
  localparam logic [DurW-1:0] T_SH_ZERO = 16'd1000;
  localparam logic [DurW-1:0] T_SH_ONE  = 16'd2000;
  localparam logic [DurW-1:0] T_SH_GAP  = 16'd40000;

  localparam logic [WordW-1:0] MCE_KEY = 32'h800f0000;

  typedef struct packed {
    logic [2:0]      kind;
    logic [CntW-1:0] n;
    logic [4:0]      vsel;
    logic            rc6;
    logic [DurW-1:0] m0;
    logic [DurW-1:0] m1;
    logic [DurW-1:0] s0;
    logic [DurW-1:0] s1;
  } seg_t;

  typedef struct packed {
    logic            load;
    logic            step;
    logic            emit_final;
    logic            emit_bad;
    logic [SegW-1:0] seg;
    logic [BitW-1:0] bit_i;
    logic            half;
  } irfe_cmd_t;

  typedef struct packed {
    logic            ok;
    logic            is_end;
    logic            single;
    logic [CntW-1:0] n;
    logic            done;
    logic            free;
  } irfe_stat_t;

  function automatic seg_t mk(input logic [2:0] kind, input logic [CntW-1:0] n,
                              input logic [4:0] vsel, input logic rc6,
                              input logic [DurW-1:0] m0, input logic [DurW-1:0] m1,
                              input logic [DurW-1:0] s0, input logic [DurW-1:0] s1);
    seg_t r;
    r.kind = kind;
    r.n    = n;
    r.vsel = vsel;
    r.rc6  = rc6;
    r.m0   = m0;
    r.m1   = m1;
    r.s0   = s0;
    r.s1   = s1;
    return r;
  endfunction

  function automatic seg_t one_shot(input logic [2:0] kind, input logic [DurW-1:0] len);
    return mk(kind, 6'd1, V_ZERO, 1'b0, len, len, len, len);
  endfunction

  function automatic seg_t nec_bits(input logic [4:0] vsel, input logic [CntW-1:0] n);
    return mk(K_DIST, n, vsel, 1'b0, T_NEC, T_NEC, T_NEC, T_NEC_1);
  endfunction

  function automatic seg_t sh_bits(input logic [4:0] vsel, input logic [CntW-1:0] n);
    return mk(K_DIST, n, vsel, 1'b0, T_SH_MARK, T_SH_MARK, T_SH_ZERO, T_SH_ONE);
  endfunction

  function automatic seg_t rc5_bits(input logic [4:0] vsel, input logic [CntW-1:0] n);
    return mk(K_MANCH, n, vsel, 1'b0, T_RC5, T_RC5, T_RC5, T_RC5);
  endfunction

  function automatic seg_t rc6_bits(input logic [4:0] vsel, input logic [CntW-1:0] n,
                                    input logic [DurW-1:0] len);
    return mk(K_MANCH, n, vsel, 1'b1, len, len, len, len);
  endfunction

  function automatic logic [WordW-1:0] proto_mask(input logic [ProtoW-1:0] p);
    logic [WordW-1:0] m;
    case (p)
      P_RC5:     m = 32'h00001f7f;
      P_RC5X:    m = 32'h001f7f3f;
      P_RC5SZ:   m = 32'h00002fff;
      P_SONY12:  m = 32'h001f007f;
      P_SONY15:  m = 32'h00ff007f;
      P_SONY20:  m = 32'h001fff7f;
      P_JVC:     m = 32'h0000ffff;
      P_NEC:     m = 32'h0000ffff;
      P_NECX:    m = 32'h00ffffff;
      P_NEC32:   m = 32'hffffffff;
      P_SANYO:   m = 32'h001fffff;
      P_RC6_0:   m = 32'h0000ffff;
      P_RC6_20:  m = 32'h000fffff;
      P_RC6_24:  m = 32'h00ffffff;
      P_RC6_32:  m = 32'hffffffff;
      P_RC6_MCE: m = 32'hffff7fff;
      P_SHARP:   m = 32'h00001fff;
      default:   m = '0;
    endcase
    return m;
  endfunction

  function automatic logic frame_ok(input logic [ProtoW-1:0] p, input logic [WordW-1:0] s);
    logic r;
    if (p > P_SHARP) begin
      r = 1'b0;
    end else if ((s & ~proto_mask(p)) != '0) begin
      r = 1'b0;
    end else begin
      case (p)
        P_NECX:    r = (s[23:16] != ~s[15:8]);
        P_NEC32:   r = (s[31:24] != ~s[23:16]);
        P_RC6_MCE: r = (s[31:16] == MCE_KEY[31:16]);
        P_RC6_32:  r = (s[31:16] != MCE_KEY[31:16]);
        default:   r = 1'b1;
      endcase
    end
    return r;
  endfunction

  function automatic logic [WordW-1:0] seg_value(input logic [4:0] vsel,
                                                 input logic [WordW-1:0] s);
    logic [WordW-1:0] v;
    case (vsel)
      V_ONE:    v = 32'd1;
      V_TWO:    v = 32'd2;
      V_EIGHT:  v = 32'd8;
      V_FOURT:  v = 32'd14;
      V_RC5F:   v = {31'd0, ~s[6]};
      V_RC5XF:  v = {31'd0, ~s[14]};
      V_RC5SZF: v = {31'd0, s[13]};
      V_S:      v = s;
      V_S6:     v = {6'd0, s[31:6]};
      V_S8:     v = {8'd0, s[31:8]};
      V_S16:    v = {16'd0, s[31:16]};
      V_S24:    v = {24'd0, s[31:24]};
      V_NS:     v = ~s;
      V_NS8:    v = ~{8'd0, s[31:8]};
      V_SONY12: v = {20'd0, s[20:16], s[6:0]};
      V_SONY15: v = {17'd0, s[23:16], s[6:0]};
      V_SONY20: v = {12'd0, s[15:8], s[20:16], s[6:0]};
      V_JVC:    v = {16'd0, s[7:0], s[15:8]};
      default:  v = '0;
    endcase
    return v;
  endfunction

  function automatic seg_t seg_info(input logic [ProtoW-1:0] p, input logic [SegW-1:0] g);
    seg_t r;
    r = one_shot(K_END, '0);
    case (p)
      P_RC5, P_RC5X, P_RC5SZ: begin
        case (g)
          4'd0: r = one_shot(K_MARK, T_RC5);
          4'd1: r = rc5_bits((p == P_RC5) ? V_RC5F : ((p == P_RC5X) ? V_RC5XF : V_RC5SZF),
                             6'd1);
          4'd2: r = rc5_bits(V_ZERO, 6'd1);
          4'd3: begin
            if (p == P_RC5) begin
              r = rc5_bits(V_S8, 6'd5);
            end else if (p == P_RC5SZ) begin
              r = rc5_bits(V_S6, 6'd6);
            end else begin
              r = rc5_bits(V_S16, 6'd5);
            end
          end
          4'd4: begin
            if (p == P_RC5X) begin
              r = one_shot(K_GAP, T_RC5_GAP);
            end else begin
              r = rc5_bits(V_S, 6'd6);
            end
          end
          4'd5: if (p == P_RC5X) r = rc5_bits(V_S8, 6'd6);
          4'd6: if (p == P_RC5X) r = rc5_bits(V_S, 6'd6);
          default: r = one_shot(K_END, '0);
        endcase
      end
      P_SONY12, P_SONY15, P_SONY20: begin
        case (g)
          4'd0: r = one_shot(K_MARK, T_SONY_LD);
          4'd1: r = one_shot(K_GAP, T_SONY);
          4'd2: begin
            if (p == P_SONY12) begin
              r = mk(K_DIST, 6'd12, V_SONY12, 1'b0, T_SONY, T_SONY_2, T_SONY, T_SONY);
            end else if (p == P_SONY15) begin
              r = mk(K_DIST, 6'd15, V_SONY15, 1'b0, T_SONY, T_SONY_2, T_SONY, T_SONY);
            end else begin
              r = mk(K_DIST, 6'd20, V_SONY20, 1'b0, T_SONY, T_SONY_2, T_SONY, T_SONY);
            end
          end
          default: r = one_shot(K_END, '0);
        endcase
      end
      P_JVC: begin
        case (g)
          4'd0: r = one_shot(K_MARK, T_JVC_LM);
          4'd1: r = one_shot(K_GAP, T_JVC_LS);
          4'd2: r = mk(K_DIST, 6'd16, V_JVC, 1'b0, T_JVC, T_JVC, T_JVC, T_JVC_3);
          4'd3: r = one_shot(K_MARK, T_JVC);
          default: r = one_shot(K_END, '0);
        endcase
      end
      P_NEC, P_NECX, P_NEC32, P_SANYO: begin
        case (g)
          4'd0: r = one_shot(K_MARK, T_NEC_LM);
          4'd1: r = one_shot(K_GAP, T_NEC_LS);
          4'd2: begin
            case (p)
              P_NEC, P_SANYO: r = nec_bits(V_S8, (p == P_SANYO) ? 6'd13 : 6'd8);
              P_NECX:         r = nec_bits(V_S16, 6'd8);
              default:        r = nec_bits(V_S24, 6'd8);
            endcase
          end
          4'd3: begin
            case (p)
              P_NEC, P_SANYO: r = nec_bits(V_NS8, (p == P_SANYO) ? 6'd13 : 6'd8);
              P_NECX:         r = nec_bits(V_S8, 6'd8);
              default:        r = nec_bits(V_S16, 6'd8);
            endcase
          end
          4'd4: r = nec_bits((p == P_NEC32) ? V_S8 : V_S, 6'd8);
          4'd5: r = nec_bits((p == P_NEC32) ? V_S : V_NS, 6'd8);
          4'd6: r = one_shot(K_MARK, T_NEC);
          default: r = one_shot(K_END, '0);
        endcase
      end
      P_RC6_0, P_RC6_20, P_RC6_24, P_RC6_32, P_RC6_MCE: begin
        case (g)
          4'd0: r = one_shot(K_MARK, T_RC6_LD);
          4'd1: r = one_shot(K_GAP, T_RC6_2);
          4'd2: r = rc6_bits((p == P_RC6_0) ? V_EIGHT : V_FOURT, 6'd4, T_RC6);
          4'd3: r = rc6_bits(V_ZERO, 6'd1, T_RC6_2);
          4'd4: begin
            case (p)
              P_RC6_0:  r = rc6_bits(V_S, 6'd16, T_RC6);
              P_RC6_20: r = rc6_bits(V_S, 6'd20, T_RC6);
              P_RC6_24: r = rc6_bits(V_S, 6'd24, T_RC6);
              default:  r = rc6_bits(V_S, 6'd32, T_RC6);
            endcase
          end
          default: r = one_shot(K_END, '0);
        endcase
      end
      P_SHARP: begin
        case (g)
          4'd0: r = sh_bits(V_S8, 6'd5);
          4'd1: r = sh_bits(V_S, 6'd8);
          4'd2: r = sh_bits(V_ONE, 6'd2);
          4'd3: r = one_shot(K_MARK, T_SH_MARK);
          4'd4: r = one_shot(K_GAP, T_SH_GAP);
          4'd5: r = sh_bits(V_S8, 6'd5);
          4'd6: r = sh_bits(V_NS, 6'd8);
          4'd7: r = sh_bits(V_TWO, 6'd2);
          4'd8: r = one_shot(K_MARK, T_SH_MARK);
          default: r = one_shot(K_END, '0);
        endcase
      end
      default: r = one_shot(K_END, '0);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/ir_remote_frame_encoder.sv */
// Top level of the consumer IR frame encoder: sequencer plus datapath.
// Depends on irfe_pkg, irfe_ctrl and irfe_datapath.
//
//   channel | ports                                            | role
//   in      | in_valid, in_stall, in_protocol, in_scancode     | one request per frame
//   out     | out_valid, out_stall, out_pulse_us, out_space_us,| mark/space pairs,
//           | out_last, out_invalid                            | last flags end of frame
//
// From one accept to the next: the accept, the check, a step per lone mark or gap
// segment and per half-bit, a step that sees the end, then the write of the final pair.
// A rejected code goes from the check straight to writing its invalid pair.
// The segment sequencer issues one half-bit per cycle while no stalled result holds it.
// Synchronous active-low reset clears the sequencer and the result valid.
// A stalled result holds the sequencer only when a new pair has to be written.
`default_nettype none
module ir_remote_frame_encoder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [irfe_pkg::ProtoW-1:0] in_protocol,
  input  wire logic [irfe_pkg::WordW-1:0]  in_scancode,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [irfe_pkg::PulseW-1:0]      out_pulse_us,
  output logic [irfe_pkg::SpaceW-1:0]      out_space_us,
  output logic                             out_last,
  output logic                             out_invalid
);
  import irfe_pkg::*;

  irfe_cmd_t  cmd;
  irfe_stat_t st;

  irfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  irfe_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_protocol  (in_protocol),
    .in_scancode  (in_scancode),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pulse_us (out_pulse_us),
    .out_space_us (out_space_us),
    .out_last     (out_last),
    .out_invalid  (out_invalid)
  );

endmodule
`default_nettype wire

/* rtl/irfe_ctrl.sv */
// Sequencer for the IR frame encoder: walks segments, bits and half-bits.
// Depends on irfe_pkg.
`default_nettype none
module irfe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire irfe_pkg::irfe_stat_t st,
  output irfe_pkg::irfe_cmd_t     cmd
);
  import irfe_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_BAD   = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [SegW-1:0] seg_r, seg_nxt;
  logic [BitW-1:0] bit_r, bit_nxt;
  logic            half_r, half_nxt;
  logic [CntW-1:0] n_m1;

  assign in_stall = (state_r != S_IDLE);
  assign n_m1     = st.n - 6'd1;

  always_comb begin
    state_nxt      = state_r;
    seg_nxt        = seg_r;
    bit_nxt        = bit_r;
    half_nxt       = half_r;
    cmd.load       = 1'b0;
    cmd.step       = 1'b0;
    cmd.emit_final = 1'b0;
    cmd.emit_bad   = 1'b0;
    cmd.seg        = seg_r;
    cmd.bit_i      = bit_r;
    cmd.half       = half_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          seg_nxt   = '0;
          bit_nxt   = '0;
          half_nxt  = 1'b0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: state_nxt = st.ok ? S_RUN : S_BAD;
      S_RUN: begin
        if (st.is_end) begin
          state_nxt = S_FINAL;
        end else begin
          cmd.step = 1'b1;
          if (st.done) begin
            if (st.single) begin
              seg_nxt = seg_r + 4'd1;
            end else if (!half_r) begin
              half_nxt = 1'b1;
            end else begin
              half_nxt = 1'b0;
              if ({1'b0, bit_r} == n_m1) begin
                bit_nxt = '0;
                seg_nxt = seg_r + 4'd1;
              end else begin
                bit_nxt = bit_r + 5'd1;
              end
            end
          end
        end
      end
      S_FINAL: begin
        cmd.emit_final = 1'b1;
        if (st.free) state_nxt = S_IDLE;
      end
      S_BAD: begin
        cmd.emit_bad = 1'b1;
        if (st.free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seg_r   <= '0;
      bit_r   <= '0;
      half_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seg_r   <= seg_nxt;
      bit_r   <= bit_nxt;
      half_r  <= half_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/irfe_datapath.sv */
// Datapath for the IR frame encoder: latched item, mark/space merging, result register.
// Depends on irfe_pkg and ir_remote_frame_encoder_defines.svh.
`default_nettype none
`include "ir_remote_frame_encoder_defines.svh"
module irfe_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [irfe_pkg::ProtoW-1:0]   in_protocol,
  input  wire logic [irfe_pkg::WordW-1:0]    in_scancode,
  input  wire irfe_pkg::irfe_cmd_t           cmd,
  output irfe_pkg::irfe_stat_t               st,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [irfe_pkg::PulseW-1:0]        out_pulse_us,
  output logic [irfe_pkg::SpaceW-1:0]        out_space_us,
  output logic                               out_last,
  output logic                               out_invalid
);
  import irfe_pkg::*;

  logic [WordW-1:0]  word_r;
  logic [ProtoW-1:0] proto_r;
  logic [DurW-1:0]   acc_r, acc_nxt;
  logic [DurW-1:0]   held_r, held_nxt;
  logic              out_valid_r;
  logic [PulseW-1:0] out_pulse_r;
  logic [SpaceW-1:0] out_space_r;
  logic              out_last_r, out_invalid_r;

  seg_t            sg;
  logic [WordW-1:0] v;
  logic [CntW-1:0] idx6;
  logic [BitW-1:0] idx;
  logic            bitv, is_mark, need_emit, free, done;
  logic [DurW-1:0] len;

  assign sg   = seg_info(proto_r, cmd.seg);
  assign v    = seg_value(sg.vsel, word_r);
  assign idx6 = sg.n - 6'd1 - {1'b0, cmd.bit_i};
  assign idx  = (sg.kind == K_MANCH) ? idx6[BitW-1:0] : cmd.bit_i;
  assign bitv = v[idx];
  assign free = !out_valid_r || !out_stall;

  always_comb begin
    is_mark = 1'b0;
    len     = sg.m0;
    case (sg.kind)
      K_MARK: is_mark = 1'b1;
      K_GAP:  is_mark = 1'b0;
      K_DIST: begin
        is_mark = !cmd.half;
        if (!cmd.half) begin
          len = bitv ? sg.m1 : sg.m0;
        end else begin
          len = bitv ? sg.s1 : sg.s0;
        end
      end
      K_MANCH: is_mark = ((bitv == sg.rc6) != cmd.half);
      default: is_mark = 1'b0;
    endcase
  end

  assign need_emit = is_mark && (acc_r != '0);
  assign done      = cmd.step && (!need_emit || free);

  assign st.ok     = frame_ok(proto_r, word_r);
  assign st.is_end = (sg.kind == K_END);
  assign st.single = (sg.kind == K_MARK) || (sg.kind == K_GAP);
  assign st.n      = sg.n;
  assign st.done   = done;
  assign st.free   = free;

  always_comb begin
    acc_nxt  = acc_r;
    held_nxt = held_r;
    if (cmd.load) begin
      acc_nxt  = '0;
      held_nxt = '0;
    end else if (done) begin
      if (is_mark) begin
        if (acc_r != '0) begin
          held_nxt = len;
          acc_nxt  = '0;
        end else begin
          held_nxt = held_r + len;
        end
      end else begin
        acc_nxt = acc_r + len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r  <= '0;
      proto_r <= '0;
      acc_r   <= '0;
      held_r  <= '0;
    end else begin
      if (cmd.load) begin
        word_r  <= in_scancode;
        proto_r <= in_protocol;
      end
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (free) begin
      out_valid_r <= (done && need_emit) || cmd.emit_final || cmd.emit_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      if (cmd.emit_bad) begin
        out_pulse_r   <= '0;
        out_space_r   <= '0;
        out_last_r    <= 1'b1;
        out_invalid_r <= 1'b1;
      end else if (cmd.emit_final) begin
        out_pulse_r   <= held_r[PulseW-1:0];
        out_space_r   <= '0;
        out_last_r    <= 1'b1;
        out_invalid_r <= 1'b0;
      end else if (done && need_emit) begin
        out_pulse_r   <= held_r[PulseW-1:0];
        out_space_r   <= acc_r;
        out_last_r    <= 1'b0;
        out_invalid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pulse_us = out_pulse_r;
  assign out_space_us = out_space_r;
  assign out_last     = out_last_r;
  assign out_invalid  = out_invalid_r;

  `IRFE_ASSERT(a_bad_is_last, out_valid_r && out_invalid_r |-> out_last_r && out_pulse_r == '0, "invalid beat must be a lone last beat")
  `IRFE_ASSERT(a_load_clears, cmd.load |=> acc_r == '0 && held_r == '0, "merge state not cleared on load")
  `IRFE_ASSERT(a_last_no_space, out_valid_r && out_last_r |-> out_space_r == '0, "last beat carries a space")
  `IRFE_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule
`default_nettype wire

/* dv/ir_remote_frame_encoder_test.sv */
// Self-checking test of the IR frame encoder: directed table, then random frames.
// Predicts every mark/space pair in a behavioral model and compares each beat.
// Depends on irfe_pkg and ir_remote_frame_encoder.
`default_nettype none
module ir_remote_frame_encoder_test;
  import irfe_pkg::*;

  localparam int NumRandom = 76;
  localparam int WdLimit   = 20000;
  localparam int MaxPairs  = 44;
  localparam int HoldLen   = 600;

  typedef struct packed {
    logic [PulseW-1:0] pulse;
    logic [SpaceW-1:0] space;
    logic              last;
    logic              bad;
  } pair_t;

  typedef struct packed {
    logic [ProtoW-1:0] proto;
    logic [WordW-1:0]  code;
    logic              typed;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ProtoW-1:0] in_protocol = '0;
  logic [WordW-1:0] in_scancode = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PulseW-1:0] out_pulse_us;
  logic [SpaceW-1:0] out_space_us;
  logic out_last;
  logic out_invalid;

  pair_t pending_pairs[$];
  logic [15:0] space_acc, mark_acc;
  int pair_cnt;
  int errors = 0;
  int beats_checked = 0;
  int frames_sent = 0;
  int idle_phase = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  ir_remote_frame_encoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_protocol(in_protocol), .in_scancode(in_scancode),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pulse_us(out_pulse_us), .out_space_us(out_space_us),
    .out_last(out_last), .out_invalid(out_invalid)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] code_mask(input logic [4:0] p);
    logic [31:0] m;
    case (p)
      P_RC5:     m = 32'h00001f7f;
      P_RC5X:    m = 32'h001f7f3f;
      P_RC5SZ:   m = 32'h00002fff;
      P_SONY12:  m = 32'h001f007f;
      P_SONY15:  m = 32'h00ff007f;
      P_SONY20:  m = 32'h001fff7f;
      P_NECX:    m = 32'h00ffffff;
      P_NEC32:   m = 32'hffffffff;
      P_SANYO:   m = 32'h001fffff;
      P_RC6_20:  m = 32'h000fffff;
      P_RC6_24:  m = 32'h00ffffff;
      P_RC6_32:  m = 32'hffffffff;
      P_RC6_MCE: m = 32'hffff7fff;
      P_SHARP:   m = 32'h00001fff;
      P_JVC, P_NEC, P_RC6_0: m = 32'h0000ffff;
      default:   m = 32'h0;
    endcase
    return m;
  endfunction

  function automatic bit code_accepted(input logic [4:0] p, input logic [31:0] s);
    if (p > P_SHARP) return 1'b0;
    if ((s & ~code_mask(p)) != 0) return 1'b0;
    case (p)
      P_NECX:    return (s[23:16] ^ ~s[15:8]) != 8'd0;
      P_NEC32:   return (s[31:24] ^ ~s[23:16]) != 8'd0;
      P_RC6_MCE: return s[31:16] == 16'h800f;
      P_RC6_32:  return s[31:16] != 16'h800f;
      default:   return 1'b1;
    endcase
  endfunction

  task automatic push_pair(input logic [15:0] p, input logic [15:0] s, input bit l, input bit b);
    if (pair_cnt < MaxPairs) begin
      pending_pairs.push_back('{p[PulseW-1:0], s, l, b});
      pair_cnt++;
    end
  endtask

  task automatic add_mark(input logic [15:0] len);
    if (space_acc != 0) begin
      push_pair(mark_acc, space_acc, 1'b0, 1'b0);
      mark_acc = len;
      space_acc = 0;
    end else begin
      mark_acc = mark_acc + len;
    end
  endtask

  task automatic add_space(input logic [15:0] len);
    space_acc = space_acc + len;
  endtask

  task automatic dist_run(input logic [31:0] v, input int n, input logic [15:0] m,
                          input logic [15:0] s0, input logic [15:0] s1);
    for (int i = 0; i < n; i++) begin
      add_mark(m);
      add_space(v[i] ? s1 : s0);
    end
  endtask

  task automatic manch_run(input logic [31:0] v, input int n, input logic [15:0] len,
                           input bit rc6);
    for (int i = n - 1; i >= 0; i--) begin
      if (v[i] == rc6) begin
        add_mark(len);
        add_space(len);
      end else begin
        add_space(len);
        add_mark(len);
      end
    end
  endtask

  task automatic predict_frame(input logic [4:0] p, input logic [31:0] s);
    logic [31:0] sb;
    int n;
    pair_cnt = 0;
    space_acc = 0;
    mark_acc = 0;
    if (!code_accepted(p, s)) begin
      push_pair(16'd0, 16'd0, 1'b1, 1'b1);
      return;
    end
    case (p)
      P_RC5, P_RC5X, P_RC5SZ: begin
        add_mark(T_RC5);
        if (p == P_RC5) begin
          manch_run({31'd0, ~s[6]}, 1, T_RC5, 1'b0);
          manch_run(32'd0, 1, T_RC5, 1'b0);
          manch_run(s >> 8, 5, T_RC5, 1'b0);
          manch_run(s, 6, T_RC5, 1'b0);
        end else if (p == P_RC5SZ) begin
          manch_run({31'd0, s[13]}, 1, T_RC5, 1'b0);
          manch_run(32'd0, 1, T_RC5, 1'b0);
          manch_run(s >> 6, 6, T_RC5, 1'b0);
          manch_run(s, 6, T_RC5, 1'b0);
        end else begin
          manch_run({31'd0, ~s[14]}, 1, T_RC5, 1'b0);
          manch_run(32'd0, 1, T_RC5, 1'b0);
          manch_run(s >> 16, 5, T_RC5, 1'b0);
          add_space(T_RC5_GAP);
          manch_run(s >> 8, 6, T_RC5, 1'b0);
          manch_run(s, 6, T_RC5, 1'b0);
        end
      end
      P_SONY12, P_SONY15, P_SONY20: begin
        sb = {25'd0, s[6:0]};
        if (p == P_SONY12) begin
          sb[11:7] = s[20:16]; n = 12;
        end else if (p == P_SONY15) begin
          sb[14:7] = s[23:16]; n = 15;
        end else begin
          sb[11:7] = s[20:16]; sb[19:12] = s[15:8]; n = 20;
        end
        add_mark(T_SONY_LD);
        add_space(T_SONY);
        for (int i = 0; i < n; i++) begin
          add_mark(sb[i] ? T_SONY_2 : T_SONY);
          add_space(T_SONY);
        end
      end
      P_JVC: begin
        add_mark(T_JVC_LM);
        add_space(T_JVC_LS);
        dist_run({16'd0, s[7:0], s[15:8]}, 16, T_JVC, T_JVC, T_JVC_3);
        add_mark(T_JVC);
      end
      P_NEC, P_NECX, P_NEC32, P_SANYO: begin
        add_mark(T_NEC_LM);
        add_space(T_NEC_LS);
        if (p == P_NEC) begin
          dist_run(s >> 8, 8, T_NEC, T_NEC, T_NEC_1);
          dist_run(~(s >> 8), 8, T_NEC, T_NEC, T_NEC_1);
          dist_run(s, 8, T_NEC, T_NEC, T_NEC_1);
          dist_run(~s, 8, T_NEC, T_NEC, T_NEC_1);
        end else if (p == P_NECX) begin
          dist_run(s >> 16, 8, T_NEC, T_NEC, T_NEC_1);
          dist_run(s >> 8, 8, T_NEC, T_NEC, T_NEC_1);
          dist_run(s, 8, T_NEC, T_NEC, T_NEC_1);
          dist_run(~s, 8, T_NEC, T_NEC, T_NEC_1);
        end else if (p == P_NEC32) begin
          dist_run(s >> 24, 8, T_NEC, T_NEC, T_NEC_1);
          dist_run(s >> 16, 8, T_NEC, T_NEC, T_NEC_1);
          dist_run(s >> 8, 8, T_NEC, T_NEC, T_NEC_1);
          dist_run(s, 8, T_NEC, T_NEC, T_NEC_1);
        end else begin
          dist_run(s >> 8, 13, T_NEC, T_NEC, T_NEC_1);
          dist_run(~(s >> 8), 13, T_NEC, T_NEC, T_NEC_1);
          dist_run(s, 8, T_NEC, T_NEC, T_NEC_1);
          dist_run(~s, 8, T_NEC, T_NEC, T_NEC_1);
        end
        add_mark(T_NEC);
      end
      P_SHARP: begin
        dist_run(s >> 8, 5, T_SH_MARK, T_SH_ZERO, T_SH_ONE);
        dist_run(s, 8, T_SH_MARK, T_SH_ZERO, T_SH_ONE);
        dist_run(32'd1, 2, T_SH_MARK, T_SH_ZERO, T_SH_ONE);
        add_mark(T_SH_MARK);
        add_space(T_SH_GAP);
        dist_run(s >> 8, 5, T_SH_MARK, T_SH_ZERO, T_SH_ONE);
        dist_run(~s, 8, T_SH_MARK, T_SH_ZERO, T_SH_ONE);
        dist_run(32'd2, 2, T_SH_MARK, T_SH_ZERO, T_SH_ONE);
        add_mark(T_SH_MARK);
      end
      default: begin
        n = (p == P_RC6_0) ? 16 : (p == P_RC6_20) ? 20 : (p == P_RC6_24) ? 24 : 32;
        add_mark(T_RC6_LD);
        add_space(T_RC6_2);
        manch_run((p == P_RC6_0) ? 32'd8 : 32'd14, 4, T_RC6, 1'b1);
        manch_run(32'd0, 1, T_RC6_2, 1'b1);
        manch_run(s, n, T_RC6, 1'b1);
      end
    endcase
    space_acc = 0;
    push_pair(mark_acc, 16'd0, 1'b1, 1'b0);
  endtask

  function automatic row_t random_frame();
    row_t r;
    r.typed = 1'b0;
    r.code = $urandom();
    if ($urandom_range(99) < 15) begin
      r.proto = ProtoW'($urandom_range(31));
    end else begin
      r.proto = ProtoW'($urandom_range(P_SHARP));
      r.code &= code_mask(r.proto);
      if (r.proto == P_RC6_MCE) r.code[31:16] = 16'h800f;
    end
    return r;
  endfunction

  row_t frame_table[] = '{
    '{P_RC5, 32'h00000000, 1'b0}, '{P_RC5, 32'h00001f7f, 1'b0},
    '{P_RC5X, 32'h001f7f3f, 1'b0}, '{P_RC5SZ, 32'h00002fff, 1'b0},
    '{P_SONY12, 32'h001f007f, 1'b0}, '{P_SONY15, 32'h00ff007f, 1'b0},
    '{P_SONY20, 32'h001fff7f, 1'b0}, '{P_JVC, 32'h0000ffff, 1'b0},
    '{P_NEC, 32'h0000ffff, 1'b0}, '{P_NECX, 32'h00ffffff, 1'b0},
    '{P_NEC32, 32'hffffffff, 1'b0}, '{P_SANYO, 32'h001fffff, 1'b0},
    '{P_RC6_0, 32'h0000ffff, 1'b0}, '{P_RC6_20, 32'h000fffff, 1'b0},
    '{P_RC6_24, 32'h00ffffff, 1'b0}, '{P_RC6_32, 32'hffffffff, 1'b0},
    '{P_RC6_MCE, 32'h800f7fff, 1'b0}, '{P_SHARP, 32'h00001fff, 1'b0},
    '{P_RC5, 32'h00000080, 1'b1}, '{P_NECX, 32'h0000ff00, 1'b1},
    '{P_NEC32, 32'h12ed0000, 1'b1}, '{P_RC6_MCE, 32'h00000000, 1'b1},
    '{P_RC6_32, 32'h800f0000, 1'b1}, '{5'd17, 32'h00000000, 1'b1},
    '{5'd31, 32'hffffffff, 1'b1}
  };

  task automatic send_frame(input row_t r);
    int idle_pct;
    idle_pct = (idle_phase == 1) ? 78 : (idle_phase == 3) ? 30 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_protocol <= r.proto;
    in_scancode <= r.code;
    do @(posedge clk); while (in_stall);
    if (r.typed) pending_pairs.push_back('{'0, '0, 1'b1, 1'b1});
    else predict_frame(r.proto, r.code);
    frames_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt = HoldLen;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) <
                    ((idle_phase == 2) ? 78 : (idle_phase == 3) ? 30 : 0));
    end
  end

  always @(posedge clk) begin
    pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_checked++;
      if (pending_pairs.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual %0d/%0d last %0b inv %0b",
                 $time, out_pulse_us, out_space_us, out_last, out_invalid);
      end else begin
        want = pending_pairs.pop_front();
        if ({out_pulse_us, out_space_us, out_last, out_invalid} != want) begin
          errors++;
          $display("%0t: beat mismatch, expected %0d/%0d last %0b inv %0b,",
                   $time, want.pulse, want.space, want.last, want.bad,
                   " actual %0d/%0d last %0b inv %0b",
                   out_pulse_us, out_space_us, out_last, out_invalid);
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WdLimit) begin
      $display("%0t: watchdog expired, %0d beats still pending", $time, pending_pairs.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (frame_table[i]) send_frame(frame_table[i]);
    hold_req = 1'b1;
    for (int i = 0; i < NumRandom; i++) begin
      idle_phase = i / (NumRandom / 4);
      send_frame(random_frame());
    end
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d frames over all 17 protocols plus rejected codes; checked %0d beats.",
             frames_sent, beats_checked);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/irfe_pkg.sv
rtl/irfe_ctrl.sv
rtl/irfe_datapath.sv
rtl/ir_remote_frame_encoder.sv
dv/ir_remote_frame_encoder_test.sv
